// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each macro is a labeled concurrent
// assertion on the rising clock edge, switched off while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// The expression must hold at every clock edge out of reset.
`define ASSERT_ALWAYS(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) \
    else $error("invariant violated");
// Whenever the antecedent holds, the consequent must hold at the same edge.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication violated");
`else
`define ASSERT_ALWAYS(label, clk, rst, expr)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`endif
`endif

// ----- hw/rtl/fcc_pkg.sv -----
package fcc_pkg;

  // Field widths fixed by the item formats.
  localparam int TEMP_W  = 9;
  localparam int LEVEL_W = 7;

  // Fan levels are percentages.
  localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'd100;

  // Legal range and reset value of the switch-off offset register.
  localparam logic [3:0] OFFSET_MIN   = 4'd1;
  localparam logic [3:0] OFFSET_MAX   = 4'd10;
  localparam logic [3:0] OFFSET_RESET = 4'd5;

  // Fan control mode as read back on a tick; other codes mean unreadable.
  localparam logic [1:0] MODE_MANUAL = 2'd0;
  localparam logic [1:0] MODE_AUTO   = 2'd1;

  typedef enum logic [1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TICK  = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_t;

  typedef enum logic [3:0] {
    KIND_STORED      = 4'd0,
    KIND_CURVE_OK    = 4'd1,
    KIND_CURVE_BAD   = 4'd2,
    KIND_STARTED     = 4'd3,
    KIND_REFUSED     = 4'd4,
    KIND_STOPPED     = 4'd5,
    KIND_NO_CHANGE   = 4'd6,
    KIND_TAKE_MANUAL = 4'd7,
    KIND_SET_LEVEL   = 4'd8,
    KIND_ERROR       = 4'd9,
    KIND_IGNORED     = 4'd10
  } kind_t;

  // One curve point as kept in the point store.
  typedef struct packed {
    logic signed [TEMP_W-1:0] temp;
    logic [LEVEL_W-1:0]       level;
  } point_t;

  // One result word.
  typedef struct packed {
    kind_t              kind;
    logic [LEVEL_W-1:0] level;
    logic               restore;
    logic               last;
  } result_t;

  function automatic result_t make_result(kind_t kind, logic [LEVEL_W-1:0] level,
                                          logic restore, logic last);
    result_t r;
    r.kind    = kind;
    r.level   = level;
    r.restore = restore;
    r.last    = last;
    return r;
  endfunction

endpackage

// ----- hw/rtl/fcc_channels.sv -----
// Command channel: one word per command, curve point or control tick.
interface fcc_req_if;
  logic                                valid;
  logic                                ready;
  fcc_pkg::cmd_t                       command;
  logic signed [fcc_pkg::TEMP_W-1:0]   temperature;
  logic [fcc_pkg::LEVEL_W-1:0]         fan_level;
  logic                                last_point;
  logic [1:0]                          mode_reading;
  logic                                temperature_ok;
  logic                                level_ok;

  modport source (
    output valid, command, temperature, fan_level, last_point, mode_reading,
           temperature_ok, level_ok,
    input  ready
  );
  modport sink (
    input  valid, command, temperature, fan_level, last_point, mode_reading,
           temperature_ok, level_ok,
    output ready
  );
endinterface

// Result channel: one or two words per command word.
interface fcc_rsp_if;
  logic                        valid;
  logic                        ready;
  fcc_pkg::kind_t              kind;
  logic [fcc_pkg::LEVEL_W-1:0] level_out;
  logic                        restore_auto;
  logic                        last;

  modport source (
    output valid, kind, level_out, restore_auto, last,
    input  ready
  );
  modport sink (
    input  valid, kind, level_out, restore_auto, last,
    output ready
  );
endinterface

// ----- hw/rtl/fan_curve_controller_top.sv -----
// Fan curve controller. Takes one command word at a time and answers each with one or two
// result words; ready is high only while the controller sits idle, and a finished result
// waits in the output register without holding up the next command. A control tick reads
// the level table through a registered read and gives a second result word when manual
// control is taken. Closing a curve checks the stored points one by one through the point
// store's single read port, then rebuilds the level table one entry at a time: degrees below
// the first point or past the last one are written directly, degrees between points go
// through one shared compare-and-subtract divider (7 quotient bits), and each inner point
// crossed loads the next point from the store. There is no clearing pass after reset.
`include "assert_macros.svh"

module fan_curve_controller_top #(
  parameter int TABLE_DEPTH = 100,
  parameter int MAX_POINTS  = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_wdata,
  fcc_req_if.sink     request,
  fcc_rsp_if.source   response
);
  import fcc_pkg::*;

  localparam int AW  = $clog2(TABLE_DEPTH);
  localparam int TW  = $clog2(TABLE_DEPTH + 1);
  localparam int PAW = $clog2(MAX_POINTS);
  localparam int CW  = $clog2(MAX_POINTS + 1);

  typedef enum logic [3:0] {
    S_IDLE,
    S_PUSH,
    S_TICK,
    S_TICK2,
    S_VCHK,
    S_VWAIT,
    S_VCMP,
    S_SEG,
    S_T,
    S_BWAIT,
    S_BLOAD,
    S_DIV,
    S_WR
  } state_t;

  state_t state;

  // Control state.
  logic [3:0]    offset;
  logic [CW-1:0] point_count;
  logic          too_many;
  logic          curve_ready;
  logic [AW-1:0] turn_on_temp;
  logic          running;
  logic          took_manual;

  // Captured tick readings.
  logic signed [TEMP_W-1:0] temp_r;
  logic [LEVEL_W-1:0]       lvl_r;
  logic [1:0]               mode_r;
  logic                     tok_r;
  logic                     lok_r;
  logic [AW-1:0]            look_addr;

  // Memories and their registered read data.
  point_t             pts [MAX_POINTS];
  logic [PAW-1:0]     pts_addr;
  point_t             pts_rd;
  logic [LEVEL_W-1:0] tbl [TABLE_DEPTH];
  logic [LEVEL_W-1:0] tbl_rd;

  // Curve check and table build.
  logic [CW-1:0]            vidx;
  logic signed [TEMP_W-1:0] prev_temp;
  logic signed [TEMP_W-1:0] first_temp;
  point_t                   p0;
  point_t                   p1;
  logic [CW-1:0]            nidx;
  logic                     has_next;
  logic [14:0]              num;
  logic [TW-1:0]            tcnt;
  logic [15:0]              rem;
  logic [15:0]              dsr;
  logic [LEVEL_W-1:0]       quo;
  logic [2:0]               step;

  // Pending result and whether the tick goes on after it.
  result_t res;
  logic    res_more;

  logic                 accept;
  logic                 push_out;
  logic [CW-1:0]        vidx_inc;
  logic [CW-1:0]        nidx_inc;
  logic [7:0]           seg_d;
  logic signed [7:0]    delta;
  logic signed [9:0]    t_ext;
  logic                 t_done;
  logic                 t_before;
  logic                 t_adv;
  logic                 pts_we;
  logic                 tbl_we;
  logic [LEVEL_W-1:0]   tbl_wdata;
  logic signed [9:0]    req_temp_ext;
  logic [AW-1:0]        req_addr;
  logic [7:0]           t_pos;
  logic [LEVEL_W-1:0]   cur_level;
  logic                 off_ok;
  logic                 set_level;
  logic                 v_bad;

  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;

  // The pending word moves out once the output register is free.
  assign push_out = (state == S_PUSH) && (!response.valid || response.ready);

  assign vidx_inc = vidx + 1'b1;
  assign nidx_inc = nidx + 1'b1;

  // Segment width and level step between the two current points.
  assign seg_d = 8'(p1.temp - p0.temp);
  assign delta = 8'($signed({1'b0, p1.level}) - $signed({1'b0, p0.level}));

  // Degree under construction against the current points.
  assign t_ext    = $signed({1'b0, 9'(tcnt)});
  assign t_done   = (tcnt == TW'(TABLE_DEPTH));
  assign t_before = t_ext < $signed({p0.temp[TEMP_W-1], p0.temp});
  assign t_adv    = has_next && (t_ext == $signed({p1.temp[TEMP_W-1], p1.temp}));

  // Curve check on the point just read: first at or above zero, then increasing.
  assign v_bad = (vidx == '0) ? pts_rd.temp[TEMP_W-1] : (pts_rd.temp <= prev_temp);

  // Lookup address of a tick's reading, clamped to the table.
  assign req_temp_ext = {request.temperature[TEMP_W-1], request.temperature};
  always_comb begin
    if (request.temperature[TEMP_W-1]) begin
      req_addr = '0;
    end else if (req_temp_ext > $signed(10'(TABLE_DEPTH - 1))) begin
      req_addr = AW'(TABLE_DEPTH - 1);
    end else begin
      req_addr = request.temperature[AW-1:0];
    end
  end

  // Tick decision: switch the fan off only well below the turn-on point.
  assign t_pos     = temp_r[TEMP_W-1] ? 8'd0 : temp_r[7:0];
  assign cur_level = (lvl_r > LEVEL_MAX) ? LEVEL_MAX : lvl_r;
  assign off_ok    = curve_ready && ((9'(t_pos) + 9'(offset)) < 9'(turn_on_temp));
  assign set_level = (tbl_rd != cur_level) &&
                     ((cur_level == '0) || (tbl_rd != '0) || off_ok);

  // Point store write on each stored curve point.
  assign pts_we = accept && (request.command == CMD_LOAD) &&
                  (point_count < CW'(MAX_POINTS));

  // Table writes: direct for zero and held entries, after the divide otherwise.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_wdata = quo;
    if (state == S_T && !t_done && (t_before || !has_next)) begin
      tbl_we    = 1'b1;
      tbl_wdata = t_before ? '0 : p0.level;
    end else if (state == S_WR) begin
      tbl_we = 1'b1;
    end
  end

  // Point store.
  always_ff @(posedge clk) begin
    if (pts_we) begin
      pts[point_count[PAW-1:0]] <= point_t'{temp: request.temperature,
                                            level: request.fan_level};
    end
    pts_rd <= pts[pts_addr];
  end

  // Level table.
  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl[tcnt[AW-1:0]] <= tbl_wdata;
    end
    tbl_rd <= tbl[look_addr];
  end

  // Sequencer, control state and output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      offset         <= OFFSET_RESET;
      point_count    <= '0;
      too_many       <= 1'b0;
      curve_ready    <= 1'b0;
      turn_on_temp   <= '0;
      running        <= 1'b0;
      took_manual    <= 1'b0;
      response.valid <= 1'b0;
    end else begin
      // Register write; out-of-range values are dropped.
      if (cfg_we && cfg_wdata >= OFFSET_MIN && cfg_wdata <= OFFSET_MAX) begin
        offset <= cfg_wdata;
      end

      // Output valid: set by a pushed word, cleared once the word is taken.
      if (push_out) begin
        response.valid <= 1'b1;
      end else if (response.ready) begin
        response.valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (accept) begin
            res_more <= 1'b0;
            case (request.command)
              CMD_LOAD: begin
                if (point_count < CW'(MAX_POINTS)) begin
                  point_count <= point_count + 1'b1;
                end else begin
                  too_many <= 1'b1;
                end
                if (request.last_point) begin
                  state <= S_VCHK;
                end else begin
                  res   <= make_result(KIND_STORED, '0, 1'b0, 1'b1);
                  state <= S_PUSH;
                end
              end
              CMD_START: begin
                if (curve_ready) begin
                  running <= 1'b1;
                  res     <= make_result(KIND_STARTED, '0, 1'b0, 1'b1);
                end else begin
                  res <= make_result(KIND_REFUSED, '0, 1'b0, 1'b1);
                end
                state <= S_PUSH;
              end
              CMD_STOP: begin
                running <= 1'b0;
                res     <= make_result(KIND_STOPPED, '0, 1'b0, 1'b1);
                state   <= S_PUSH;
              end
              default: begin
                temp_r    <= request.temperature;
                lvl_r     <= request.fan_level;
                mode_r    <= request.mode_reading;
                tok_r     <= request.temperature_ok;
                lok_r     <= request.level_ok;
                look_addr <= req_addr;
                state     <= S_TICK;
              end
            endcase
          end
        end

        // Hand the pending result to the output register once it is free.
        S_PUSH: begin
          if (push_out) begin
            response.kind         <= res.kind;
            response.level_out    <= res.level;
            response.restore_auto <= res.restore;
            response.last         <= res.last;
            state                 <= res_more ? S_TICK2 : S_IDLE;
          end
        end

        // Tick, first step: running check and fan control mode.
        S_TICK: begin
          if (!running) begin
            res   <= make_result(KIND_IGNORED, '0, 1'b0, 1'b1);
            state <= S_PUSH;
          end else if (mode_r != MODE_MANUAL && mode_r != MODE_AUTO) begin
            res         <= make_result(KIND_ERROR, '0, took_manual, 1'b1);
            took_manual <= 1'b0;
            running     <= 1'b0;
            state       <= S_PUSH;
          end else if (mode_r == MODE_AUTO) begin
            took_manual <= 1'b1;
            res         <= make_result(KIND_TAKE_MANUAL, '0, 1'b0, 1'b0);
            res_more    <= 1'b1;
            state       <= S_PUSH;
          end else begin
            state <= S_TICK2;
          end
        end

        // Tick, second step: reading check and table decision.
        S_TICK2: begin
          res_more <= 1'b0;
          if (!tok_r || !lok_r) begin
            res         <= make_result(KIND_ERROR, '0, took_manual, 1'b1);
            took_manual <= 1'b0;
            running     <= 1'b0;
          end else if (set_level) begin
            res <= make_result(KIND_SET_LEVEL, tbl_rd, 1'b0, 1'b1);
          end else begin
            res <= make_result(KIND_NO_CHANGE, '0, 1'b0, 1'b1);
          end
          state <= S_PUSH;
        end

        // Curve closed: count check, then read the points one by one.
        S_VCHK: begin
          if (too_many || point_count < CW'(2)) begin
            point_count <= '0;
            too_many    <= 1'b0;
            res         <= make_result(KIND_CURVE_BAD, '0, 1'b0, 1'b1);
            state       <= S_PUSH;
          end else begin
            pts_addr <= '0;
            vidx     <= '0;
            state    <= S_VWAIT;
          end
        end

        S_VWAIT: begin
          state <= S_VCMP;
        end

        S_VCMP: begin
          if (v_bad) begin
            point_count <= '0;
            too_many    <= 1'b0;
            res         <= make_result(KIND_CURVE_BAD, '0, 1'b0, 1'b1);
            state       <= S_PUSH;
          end else begin
            prev_temp <= pts_rd.temp;
            if (vidx == '0) begin
              p0         <= pts_rd;
              first_temp <= pts_rd.temp;
            end
            if (vidx == CW'(1)) begin
              p1 <= pts_rd;
            end
            if (vidx_inc == point_count) begin
              tcnt     <= '0;
              nidx     <= CW'(1);
              has_next <= 1'b1;
              state    <= S_SEG;
            end else begin
              vidx     <= vidx_inc;
              pts_addr <= vidx_inc[PAW-1:0];
              state    <= S_VWAIT;
            end
          end
        end

        // Segment entry: numerator at its first degree is l0 * d.
        S_SEG: begin
          num   <= 15'(p0.level) * 15'(seg_d);
          state <= S_T;
        end

        // One table degree: finish, write directly, cross a point, or divide.
        S_T: begin
          if (t_done) begin
            if ($unsigned(first_temp) < 9'(TABLE_DEPTH)) begin
              turn_on_temp <= first_temp[AW-1:0];
              curve_ready  <= 1'b1;
            end else begin
              turn_on_temp <= '0;
              curve_ready  <= 1'b0;
            end
            point_count <= '0;
            too_many    <= 1'b0;
            res         <= make_result(KIND_CURVE_OK, '0, 1'b0, 1'b1);
            state       <= S_PUSH;
          end else if (t_before || !has_next) begin
            tcnt <= tcnt + 1'b1;
          end else if (t_adv) begin
            p0 <= p1;
            if (nidx_inc < point_count) begin
              nidx     <= nidx_inc;
              pts_addr <= nidx_inc[PAW-1:0];
              state    <= S_BWAIT;
            end else begin
              has_next <= 1'b0;
            end
          end else begin
            rem   <= 16'({num, 1'b0}) + 16'(seg_d);
            dsr   <= {1'b0, seg_d, 7'd0};
            quo   <= '0;
            step  <= 3'd6;
            state <= S_DIV;
          end
        end

        S_BWAIT: begin
          state <= S_BLOAD;
        end

        S_BLOAD: begin
          p1    <= pts_rd;
          state <= S_SEG;
        end

        // Restoring divide, one quotient bit per cycle: (2n + d) / 2d.
        S_DIV: begin
          if (rem >= dsr) begin
            rem <= rem - dsr;
            quo <= {quo[LEVEL_W-2:0], 1'b1};
          end else begin
            quo <= {quo[LEVEL_W-2:0], 1'b0};
          end
          dsr <= dsr >> 1;
          if (step == 3'd0) begin
            state <= S_WR;
          end else begin
            step <= step - 1'b1;
          end
        end

        // Quotient goes to the table; step the numerator to the next degree.
        S_WR: begin
          num   <= 15'(16'(num) + {{8{delta[7]}}, delta});
          tcnt  <= tcnt + 1'b1;
          state <= S_T;
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Only the take-manual word leaves a command unfinished.
  `ASSERT_IMPLIES(a_last_flag, clk, rst, response.valid, (response.kind == KIND_TAKE_MANUAL) != response.last)
  // A restore request travels only with an error word.
  `ASSERT_IMPLIES(a_restore_on_error, clk, rst, response.valid && response.restore_auto, response.kind == KIND_ERROR)
  // The controller starts only on a usable curve.
  `ASSERT_IMPLIES(a_start_needs_curve, clk, rst, $rose(running), curve_ready)
  // The point counter never runs past the store.
  `ASSERT_ALWAYS(a_count_bound, clk, rst, point_count <= CW'(MAX_POINTS))

endmodule

// ----- verif/fcc_checker.sv -----
`timescale 1ns / 100ps

// Watches both channels of the fan curve controller, predicts the result words of every
// accepted command word and compares them in order with the words the block hands out.
module fcc_checker #(
  parameter int TABLE_DEPTH = 100,
  parameter int MAX_POINTS  = 16
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [3:0] cfg_wdata,
  fcc_req_if         request,
  fcc_rsp_if         response,
  output int         fail_count,
  output int         words_waiting,
  output int         ticks_ignored,
  output logic       fan_running
);
  import fcc_pkg::*;

  logic [LEVEL_W-1:0]       curve_lut [TABLE_DEPTH];
  logic signed [TEMP_W-1:0] pt_temp   [MAX_POINTS];
  logic [LEVEL_W-1:0]       pt_level  [MAX_POINTS];
  int                       n_points;
  logic                     overflow;
  logic                     lut_valid;
  int                       turn_on;
  logic                     running_q;
  logic                     manual_q;
  logic [3:0]               offset_q;
  result_t                  expected_words [$];

  task automatic push_word(kind_t kind, logic [LEVEL_W-1:0] lvl, logic restore, logic last);
    expected_words.push_back(make_result(kind, lvl, restore, last));
  endtask

  // An error stops control and hands the fan back if this block had taken it.
  task automatic push_error();
    push_word(KIND_ERROR, '0, manual_q, 1'b1);
    manual_q  = 1'b0;
    running_q = 1'b0;
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] fcc_checker: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin : track
    int      t;
    int      i;
    int      d;
    int      k;
    int      l0;
    int      l1;
    int      num;
    int      v;
    int      cur;
    int      want;
    bit      good;
    result_t got;
    result_t head;
    if (rst) begin
      n_points      = 0;
      overflow      = 1'b0;
      lut_valid     = 1'b0;
      turn_on       = 0;
      running_q     = 1'b0;
      manual_q      = 1'b0;
      offset_q      = OFFSET_RESET;
      fail_count    = 0;
      ticks_ignored = 0;
      expected_words.delete();
    end else begin
      // Offset writes outside the legal range keep the old value.
      if (cfg_we && cfg_wdata >= OFFSET_MIN && cfg_wdata <= OFFSET_MAX) begin
        offset_q = cfg_wdata;
      end

      // Predict the result words of an accepted command word.
      if (request.valid && request.ready) begin
        case (request.command)
          CMD_LOAD: begin
            if (n_points < MAX_POINTS) begin
              pt_temp[n_points]  = request.temperature;
              pt_level[n_points] = request.fan_level;
              n_points++;
            end else begin
              overflow = 1'b1;
            end
            if (!request.last_point) begin
              push_word(KIND_STORED, '0, 1'b0, 1'b1);
            end else begin
              // A curve needs enough points, a first temperature of at least zero and
              // strictly rising temperatures.
              good = !overflow && n_points >= 2 && pt_temp[0] >= 0;
              for (i = 1; i < n_points; i++) begin
                if (pt_temp[i] <= pt_temp[i-1]) good = 1'b0;
              end
              if (good) begin
                // One entry per degree, interpolated and rounded half away from zero.
                for (t = 0; t < TABLE_DEPTH; t++) begin
                  v = 0;
                  if (t >= pt_temp[0]) begin
                    i = 0;
                    while (i + 1 < n_points && pt_temp[i+1] <= t) i++;
                    if (i + 1 >= n_points) begin
                      v = pt_level[i];
                    end else begin
                      d   = pt_temp[i+1] - pt_temp[i];
                      k   = t - pt_temp[i];
                      l0  = int'(pt_level[i]);
                      l1  = int'(pt_level[i+1]);
                      num = l0 * d + k * (l1 - l0);
                      if (num < 0) num = 0;
                      v = (2 * num + d) / (2 * d);
                    end
                  end
                  curve_lut[t] = v[LEVEL_W-1:0];
                end
                // A curve that starts past the table is taken but cannot be started.
                if (pt_temp[0] < TABLE_DEPTH) begin
                  turn_on   = pt_temp[0];
                  lut_valid = 1'b1;
                end else begin
                  turn_on   = 0;
                  lut_valid = 1'b0;
                end
                push_word(KIND_CURVE_OK, '0, 1'b0, 1'b1);
              end else begin
                push_word(KIND_CURVE_BAD, '0, 1'b0, 1'b1);
              end
              n_points = 0;
              overflow = 1'b0;
            end
          end
          CMD_START: begin
            if (!lut_valid) begin
              push_word(KIND_REFUSED, '0, 1'b0, 1'b1);
            end else begin
              running_q = 1'b1;
              push_word(KIND_STARTED, '0, 1'b0, 1'b1);
            end
          end
          CMD_STOP: begin
            running_q = 1'b0;
            push_word(KIND_STOPPED, '0, 1'b0, 1'b1);
          end
          CMD_TICK: begin
            if (!running_q) begin
              push_word(KIND_IGNORED, '0, 1'b0, 1'b1);
              ticks_ignored++;
            end else if (request.mode_reading != MODE_MANUAL &&
                         request.mode_reading != MODE_AUTO) begin
              push_error();
            end else begin
              if (request.mode_reading == MODE_AUTO) begin
                push_word(KIND_TAKE_MANUAL, '0, 1'b0, 1'b0);
                manual_q = 1'b1;
              end
              if (!request.temperature_ok || !request.level_ok) begin
                push_error();
              end else begin
                t = request.temperature;
                if (t < 0) t = 0;
                cur = request.fan_level;
                if (cur > int'(LEVEL_MAX)) cur = int'(LEVEL_MAX);
                want = curve_lut[(t > TABLE_DEPTH - 1) ? TABLE_DEPTH - 1 : t];
                // Switching off waits until the reading is well below turn-on.
                if (want != cur && (cur == 0 || want != 0 ||
                    (lut_valid && t - turn_on < -int'(offset_q)))) begin
                  push_word(KIND_SET_LEVEL, want[LEVEL_W-1:0], 1'b0, 1'b1);
                end else begin
                  push_word(KIND_NO_CHANGE, '0, 1'b0, 1'b1);
                end
              end
            end
          end
          default: ;
        endcase
      end

      // Compare an accepted result word with the oldest prediction.
      if (response.valid && response.ready) begin
        got = make_result(response.kind, response.level_out, response.restore_auto,
                          response.last);
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("word %s arrived with nothing expected", got.kind.name()));
        end else begin
          head = expected_words.pop_front();
          if (got.kind !== head.kind) begin
            report_mismatch($sformatf("kind %0d, expected %0d", got.kind, head.kind));
          end
          if (got.level !== head.level) begin
            report_mismatch($sformatf("level_out %0d, expected %0d", got.level, head.level));
          end
          if (got.restore !== head.restore) begin
            report_mismatch($sformatf("restore_auto %0b, expected %0b", got.restore,
                                      head.restore));
          end
          if (got.last !== head.last) begin
            report_mismatch($sformatf("last %0b, expected %0b", got.last, head.last));
          end
        end
      end
    end
    words_waiting = expected_words.size();
    fan_running   = running_q;
  end

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 100ps

// Drives command words into the fan curve controller and gives the verdict; the checker
// beside the block predicts and compares every result word.
module tb_top;
  import fcc_pkg::*;

  localparam logic [1:0] MODE_UNREADABLE = 2'd2;
  localparam logic [1:0] MODE_RESERVED   = 2'd3;
  localparam int PHASES      = 6;
  localparam int PHASE_WORDS = 150;
  localparam int LONG_HOLD   = 300;
  localparam int SETTLE      = 24;

  // Curve shapes for the random part.
  typedef enum int {
    SHAPE_GOOD,
    SHAPE_CROWDED,
    SHAPE_UNSORTED,
    SHAPE_NEGATIVE,
    SHAPE_LONE,
    SHAPE_OFF_TABLE
  } shape_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [3:0] cfg_wdata;
  int         fail_count;
  int         words_waiting;
  int         ticks_ignored;
  logic       fan_running;
  int         words_sent;
  int         curve_first;
  bit         tight;
  bit         hold_req;
  int         offset_plan [PHASES] = '{1, 10, 0, 15, 11, 3};

  fcc_req_if request_ch ();
  fcc_rsp_if response_ch ();

  fan_curve_controller_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .request   (request_ch),
    .response  (response_ch)
  );

  fcc_checker u_check (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .request       (request_ch),
    .response      (response_ch),
    .fail_count    (fail_count),
    .words_waiting (words_waiting),
    .ticks_ignored (ticks_ignored),
    .fan_running   (fan_running)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Mostly no gap, often a short one, now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (tight || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(12, 45);
  endfunction

  // Offers one command word from a falling edge and returns at the falling edge after
  // it was taken.
  task automatic send_word(cmd_t cmd, int temp, int lvl, bit lastp, logic [1:0] mode,
                           bit tok, bit lok);
    int gap;
    gap = pick_idle();
    if (gap > 0) begin
      request_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    request_ch.command        = cmd;
    request_ch.temperature    = temp[TEMP_W-1:0];
    request_ch.fan_level      = lvl[LEVEL_W-1:0];
    request_ch.last_point     = lastp;
    request_ch.mode_reading   = mode;
    request_ch.temperature_ok = tok;
    request_ch.level_ok       = lok;
    request_ch.valid          = 1'b1;
    do @(posedge clk); while (request_ch.ready !== 1'b1);
    @(negedge clk);
    words_sent++;
  endtask

  task automatic point_word(int temp, int lvl, bit lastp);
    send_word(CMD_LOAD, temp, lvl, lastp, 2'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic ctrl_word(cmd_t cmd);
    send_word(cmd, $urandom_range(0, 511), $urandom_range(0, 127), 1'($urandom),
              2'($urandom), 1'($urandom), 1'($urandom));
  endtask

  task automatic tick_word(logic [1:0] mode, int temp, int lvl, bit tok, bit lok);
    send_word(CMD_TICK, temp, lvl, 1'($urandom), mode, tok, lok);
  endtask

  task automatic write_offset(logic [3:0] value);
    cfg_wdata = value;
    cfg_we    = 1'b1;
    @(negedge clk);
    cfg_we    = 1'b0;
  endtask

  // Waits for every predicted word, then lets a curve rebuild or tick run out.
  task automatic wait_drained();
    while (words_waiting != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Result side: random stalls, stretches without any, and a long hold when asked.
  initial begin : receiver
    int gap;
    response_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_req) begin
        response_ch.ready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        hold_req = 1'b0;
      end else if (tight) begin
        response_ch.ready = 1'b1;
        @(negedge clk);
      end else begin
        response_ch.ready = 1'b1;
        repeat ($urandom_range(1, ($urandom_range(0, 9) == 0) ? 80 : 8)) @(negedge clk);
        gap = pick_idle();
        if (gap > 0) begin
          response_ch.ready = 1'b0;
          repeat (gap) @(negedge clk);
        end
      end
    end
  end

  initial begin : watchdog
    #8_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  initial begin : stimulus
    int         temps [$];
    int         lvls [$];
    int         n;
    int         t;
    int         lvl;
    int         step;
    int         j;
    int         r;
    int         p;
    int         target;
    shape_t     shape;
    logic [1:0] mode;

    rst                       = 1'b1;
    cfg_we                    = 1'b0;
    cfg_wdata                 = '0;
    request_ch.valid          = 1'b0;
    request_ch.command        = CMD_LOAD;
    request_ch.temperature    = '0;
    request_ch.fan_level      = '0;
    request_ch.last_point     = 1'b0;
    request_ch.mode_reading   = MODE_MANUAL;
    request_ch.temperature_ok = 1'b0;
    request_ch.level_ok       = 1'b0;
    words_sent                = 0;
    curve_first               = 0;
    tight                     = 1'b0;
    hold_req                  = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    write_offset(OFFSET_RESET);

    // Nothing loaded yet: ticks are ignored and start is refused.
    tick_word(MODE_MANUAL, 50, 50, 1'b1, 1'b1);
    ctrl_word(CMD_START);
    // Rejected curves: a lone point, a negative first point, a repeated temperature.
    point_word(50, 50, 1'b1);
    point_word(-128, 0, 1'b0);
    point_word(10, 50, 1'b1);
    point_word(10, 10, 1'b0);
    point_word(10, 20, 1'b1);
    // A good curve whose last point lies past the table, with the top level code.
    point_word(20, 0, 1'b0);
    point_word(40, 100, 1'b0);
    point_word(255, 127, 1'b1);
    ctrl_word(CMD_START);
    ctrl_word(CMD_START);
    // Auto mode taken over, hottest reading and an over-range level.
    tick_word(MODE_AUTO, 255, 127, 1'b1, 1'b1);
    tick_word(MODE_MANUAL, -128, 0, 1'b1, 1'b1);
    // Switch-off hysteresis: far enough below turn-on, then too close to it.
    tick_word(MODE_MANUAL, 10, 50, 1'b1, 1'b1);
    tick_word(MODE_MANUAL, 17, 50, 1'b1, 1'b1);
    // Errors with and without manual control taken.
    tick_word(MODE_UNREADABLE, 30, 30, 1'b1, 1'b1);
    ctrl_word(CMD_START);
    tick_word(MODE_RESERVED, 30, 30, 1'b1, 1'b1);
    ctrl_word(CMD_START);
    tick_word(MODE_AUTO, 30, 30, 1'b0, 1'b1);
    ctrl_word(CMD_START);
    tick_word(MODE_MANUAL, 30, 30, 1'b1, 1'b0);
    ctrl_word(CMD_STOP);
    tick_word(MODE_MANUAL, 30, 30, 1'b1, 1'b1);
    request_ch.valid = 1'b0;
    wait_drained();

    // Random phases, each under its own offset setting.
    for (p = 0; p < PHASES; p++) begin
      write_offset((p == PHASES - 1) ? 4'($urandom_range(0, 15)) : 4'(offset_plan[p]));
      tight = (p == 2);
      if (p == 1 || p == 4) hold_req = 1'b1;
      target = words_sent - ticks_ignored + PHASE_WORDS;
      while (words_sent - ticks_ignored < target) begin
        r = $urandom_range(0, 99);
        if (r < 12) begin
          // Load a curve: mostly well formed, some of every broken kind.
          r = $urandom_range(0, 99);
          if (r < 65) shape = SHAPE_GOOD;
          else if (r < 72) shape = SHAPE_CROWDED;
          else if (r < 80) shape = SHAPE_UNSORTED;
          else if (r < 86) shape = SHAPE_NEGATIVE;
          else if (r < 92) shape = SHAPE_LONE;
          else shape = SHAPE_OFF_TABLE;
          case (shape)
            SHAPE_CROWDED: begin
              n    = $urandom_range(17, 19);
              t    = $urandom_range(0, 10);
              step = 8;
            end
            SHAPE_OFF_TABLE: begin
              n    = $urandom_range(2, 4);
              t    = $urandom_range(100, 240);
              step = 5;
            end
            default: begin
              n    = ($urandom_range(0, 9) == 0) ? $urandom_range(6, 16) : $urandom_range(2, 5);
              t    = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 70);
              step = (n > 8) ? 12 : 40;
            end
          endcase
          temps.delete();
          lvls.delete();
          repeat (n) begin
            if (t > 255) break;
            temps.push_back(t);
            if ($urandom_range(0, 9) == 0) lvls.push_back($urandom_range(101, 127));
            else lvls.push_back($urandom_range(0, 100));
            t = t + $urandom_range(1, step);
          end
          if ($urandom_range(0, 2) == 0) lvls[lvls.size() - 1] = 100;
          case (shape)
            SHAPE_UNSORTED: begin
              j        = $urandom_range(1, temps.size() - 1);
              temps[j] = temps[j-1] - int'($urandom_range(0, 5));
            end
            SHAPE_NEGATIVE: temps[0] = 0 - int'($urandom_range(1, 128));
            SHAPE_LONE: begin
              while (temps.size() > 1) begin
                void'(temps.pop_back());
                void'(lvls.pop_back());
              end
            end
            default: ;
          endcase
          if (shape == SHAPE_GOOD) curve_first = temps[0];
          for (j = 0; j < temps.size(); j++) begin
            point_word(temps[j], lvls[j], j == temps.size() - 1);
          end
        end else if (r < 18) begin
          ctrl_word(CMD_START);
        end else if (r < 21) begin
          ctrl_word(CMD_STOP);
        end else begin
          // A run of ticks; a stopped block is usually started again first.
          repeat ($urandom_range(3, 15)) begin
            if (!fan_running && $urandom_range(0, 9) < 8) begin
              ctrl_word(CMD_START);
            end else begin
              r = $urandom_range(0, 99);
              if (r < 70) mode = MODE_MANUAL;
              else if (r < 90) mode = MODE_AUTO;
              else if (r < 95) mode = MODE_UNREADABLE;
              else mode = MODE_RESERVED;
              r = $urandom_range(0, 99);
              if (r < 35) t = curve_first + int'($urandom_range(0, 30)) - 15;
              else if (r < 45) t = 0 - int'($urandom_range(1, 128));
              else if (r < 55) t = $urandom_range(100, 255);
              else t = $urandom_range(0, 99);
              r = $urandom_range(0, 99);
              if (r < 50) lvl = $urandom_range(0, 100);
              else if (r < 65) lvl = 0;
              else if (r < 75) lvl = $urandom_range(101, 127);
              else lvl = $urandom_range(0, 127);
              tick_word(mode, t, lvl, $urandom_range(0, 99) >= 3, $urandom_range(0, 99) >= 3);
            end
          end
        end
      end
      request_ch.valid = 1'b0;
      wait_drained();
    end

    if (fail_count == 0) $display("tb_top OK");
    else $display("tb_top NOT OK");
    $finish;
  end

endmodule
